>>> rtl/mpahd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpahd_pkg
// Types, header codes and lookup tables for the MPEG audio header decoder.
// ----------------------------------------------------------------------------
package mpahd_pkg;

  // Header field codes
  localparam logic [10:0] SYNC_WORD  = 11'h7FF;
  localparam logic [1:0]  VER_RSVD   = 2'd1;
  localparam logic [1:0]  VER_MPEG1  = 2'd3;
  localparam logic [1:0]  VER_MPEG2  = 2'd2;
  localparam logic [1:0]  VER_MPEG25 = 2'd0;
  localparam logic [1:0]  LAYER_RSVD = 2'd0;
  localparam logic [1:0]  LAYER_I    = 2'd3;
  localparam logic [1:0]  LAYER_II   = 2'd2;
  localparam logic [1:0]  LAYER_III  = 2'd1;
  localparam logic [3:0]  BRI_FREE   = 4'd0;
  localparam logic [3:0]  BRI_BAD    = 4'd15;
  localparam logic [1:0]  SFI_RSVD   = 2'd3;

  // Samples per frame
  localparam logic [10:0] SPF_LONG  = 11'd1152;
  localparam logic [10:0] SPF_HALF  = 11'd576;
  localparam logic [10:0] SPF_SHORT = 11'd384;

  // Numerator scale: slot count times 1000 (layer I: 12 slots of 4 bytes)
  localparam logic [17:0] K_LAYER_I    = 18'd12000;
  localparam logic [17:0] K_LONG_FRAME = 18'd144000;
  localparam logic [17:0] K_HALF_FRAME = 18'd72000;

  // Reciprocal scaling: q = (n * ceil(2^RCP_SHIFT / fs)) >> RCP_SHIFT is exact
  // for n < 2^26 and fs < 2^16.
  localparam int unsigned RCP_SHIFT = 43;
  localparam logic [63:0] RCP_ONE   = 64'd1 << RCP_SHIFT;

  localparam logic [30:0] RCP_44100 = 31'((RCP_ONE + 64'd44099) / 64'd44100);
  localparam logic [30:0] RCP_48000 = 31'((RCP_ONE + 64'd47999) / 64'd48000);
  localparam logic [30:0] RCP_32000 = 31'((RCP_ONE + 64'd31999) / 64'd32000);
  localparam logic [30:0] RCP_22050 = 31'((RCP_ONE + 64'd22049) / 64'd22050);
  localparam logic [30:0] RCP_24000 = 31'((RCP_ONE + 64'd23999) / 64'd24000);
  localparam logic [30:0] RCP_16000 = 31'((RCP_ONE + 64'd15999) / 64'd16000);
  localparam logic [30:0] RCP_11025 = 31'((RCP_ONE + 64'd11024) / 64'd11025);
  localparam logic [30:0] RCP_12000 = 31'((RCP_ONE + 64'd11999) / 64'd12000);
  localparam logic [30:0] RCP_8000  = 31'((RCP_ONE + 64'd7999) / 64'd8000);

  // Bitrate tables in kbit/s, indexed by bitrate index
  localparam logic [8:0] KBPS_V1_L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KBPS_V1_L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KBPS_V1_L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KBPS_V2_L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] KBPS_V2_L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // One decoded result, first output field in the lowest bits
  typedef struct packed {
    logic [11:0] frame_bytes;
    logic [10:0] samples_per_frame;
    logic [15:0] sample_rate_hz;
    logic [8:0]  bitrate_kbps;
    logic        padding;
    logic        protect_bit;
    logic [1:0]  layer_code;
    logic [1:0]  version_code;
    logic        valid_res;
  } res_t;

  // Bitrate lookup
  function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [1:0] lay,
                                             input logic [3:0] bri);
    logic [8:0] k;
    k = 9'd0;
    if (ver == VER_MPEG1) begin
      unique case (lay)
        LAYER_I:   k = KBPS_V1_L1[bri];
        LAYER_II:  k = KBPS_V1_L2[bri];
        LAYER_III: k = KBPS_V1_L3[bri];
        default:   k = 9'd0;
      endcase
    end else begin
      unique case (lay)
        LAYER_I:            k = KBPS_V2_L1[bri];
        LAYER_II, LAYER_III: k = KBPS_V2_L23[bri];
        default:            k = 9'd0;
      endcase
    end
    return k;
  endfunction

  // Sample rate lookup in Hz
  function automatic logic [15:0] fs_lookup(input logic [1:0] ver, input logic [1:0] sfi);
    logic [15:0] f;
    f = 16'd0;
    unique case ({ver, sfi})
      {VER_MPEG1, 2'd0}:  f = 16'd44100;
      {VER_MPEG1, 2'd1}:  f = 16'd48000;
      {VER_MPEG1, 2'd2}:  f = 16'd32000;
      {VER_MPEG2, 2'd0}:  f = 16'd22050;
      {VER_MPEG2, 2'd1}:  f = 16'd24000;
      {VER_MPEG2, 2'd2}:  f = 16'd16000;
      {VER_MPEG25, 2'd0}: f = 16'd11025;
      {VER_MPEG25, 2'd1}: f = 16'd12000;
      {VER_MPEG25, 2'd2}: f = 16'd8000;
      default:            f = 16'd0;
    endcase
    return f;
  endfunction

  // Reciprocal of the sample rate, same addressing as fs_lookup
  function automatic logic [30:0] rcp_lookup(input logic [1:0] ver, input logic [1:0] sfi);
    logic [30:0] r;
    r = 31'd0;
    unique case ({ver, sfi})
      {VER_MPEG1, 2'd0}:  r = RCP_44100;
      {VER_MPEG1, 2'd1}:  r = RCP_48000;
      {VER_MPEG1, 2'd2}:  r = RCP_32000;
      {VER_MPEG2, 2'd0}:  r = RCP_22050;
      {VER_MPEG2, 2'd1}:  r = RCP_24000;
      {VER_MPEG2, 2'd2}:  r = RCP_16000;
      {VER_MPEG25, 2'd0}: r = RCP_11025;
      {VER_MPEG25, 2'd1}: r = RCP_12000;
      {VER_MPEG25, 2'd2}: r = RCP_8000;
      default:            r = 31'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/mpeg_audio_header_decode_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpeg_audio_header_decode_core
// Checks one MPEG audio frame header per transaction and returns its decoded
// fields and the frame length in bytes.
// Throughput: one header per cycle while m_tready is high; four register
// stages (decode, numerator multiply, reciprocal multiply, length finish),
// each with its own valid bit.
// Reset: rst clears all stage valid bits; the pipeline comes out empty.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decode_core
  import mpahd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] header_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0] m_tdata  // valid_res, version_code[2:1], layer_code[4:3],
                               // protect_bit, padding, bitrate_kbps[15:7],
                               // sample_rate_hz[31:16], samples_per_frame[42:32],
                               // frame_bytes[54:43], zero fill
);

  // Stage valids and per-stage load enables
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // Stage payloads
  res_t        res1, res2, res3, res4;
  logic        lay1_1, lay1_2, lay1_3;
  logic [17:0] k1;
  logic [30:0] rcp1, rcp2;
  logic [25:0] n2;
  logic [11:0] q3;

  // Field decode and checks
  logic [1:0]  ver, lay, sfi;
  logic [3:0]  bri;
  logic        hdr_ok;
  res_t        res1_next;
  logic [17:0] k1_next;

  always_comb begin
    ver    = s_tdata[20:19];
    lay    = s_tdata[18:17];
    bri    = s_tdata[15:12];
    sfi    = s_tdata[11:10];
    hdr_ok = (s_tdata[31:21] == SYNC_WORD) && (ver != VER_RSVD) && (lay != LAYER_RSVD)
             && (bri != BRI_FREE) && (bri != BRI_BAD) && (sfi != SFI_RSVD);

    res1_next              = '0;
    res1_next.valid_res    = hdr_ok;
    res1_next.version_code = ver;
    res1_next.layer_code   = lay;
    res1_next.protect_bit  = s_tdata[16];
    res1_next.padding      = s_tdata[9];
    k1_next                = K_LAYER_I;
    if (hdr_ok) begin
      res1_next.bitrate_kbps   = kbps_lookup(ver, lay, bri);
      res1_next.sample_rate_hz = fs_lookup(ver, sfi);
      unique case (lay)
        LAYER_I: begin
          res1_next.samples_per_frame = SPF_SHORT;
          k1_next = K_LAYER_I;
        end
        LAYER_II: begin
          res1_next.samples_per_frame = SPF_LONG;
          k1_next = K_LONG_FRAME;
        end
        default: begin
          res1_next.samples_per_frame = (ver == VER_MPEG1) ? SPF_LONG : SPF_HALF;
          k1_next = (ver == VER_MPEG1) ? K_LONG_FRAME : K_HALF_FRAME;
        end
      endcase
    end
  end

  // Numerator and quotient arithmetic
  logic [26:0] n_full;
  logic [56:0] p_full;
  logic [11:0] q_plus;
  res_t        res4_next;

  always_comb begin
    n_full    = 27'(res1.bitrate_kbps) * 27'(k1);
    p_full    = 57'(n2) * 57'(rcp2);
    q_plus    = q3 + 12'(res3.padding);
    res4_next = res3;
    if (res3.valid_res) begin
      res4_next.frame_bytes = lay1_3 ? {q_plus[9:0], 2'b00} : q_plus;
    end else begin
      res4_next.frame_bytes = '0;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage payload registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      res1   <= res1_next;
      lay1_1 <= (s_tdata[18:17] == LAYER_I);
      k1     <= k1_next;
      rcp1   <= rcp_lookup(s_tdata[20:19], s_tdata[11:10]);
    end
    if (rdy2) begin
      res2   <= res1;
      lay1_2 <= lay1_1;
      rcp2   <= rcp1;
      n2     <= n_full[25:0];
    end
    if (rdy3) begin
      res3   <= res2;
      lay1_3 <= lay1_2;
      q3     <= p_full[RCP_SHIFT+11:RCP_SHIFT];
    end
    if (rdy4) begin
      res4 <= res4_next;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {1'b0, res4};

  // Checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    v4 && !res4.valid_res |-> (res4.frame_bytes == '0) && (res4.samples_per_frame == '0))
    else $error("invalid header with nonzero length");

  a_valid_len: assert property (@(posedge clk) disable iff (rst)
    v4 && res4.valid_res |-> (res4.frame_bytes != '0))
    else $error("valid header with zero frame length");

  a_layer1_words: assert property (@(posedge clk) disable iff (rst)
    v4 && res4.valid_res && (res4.layer_code == LAYER_I) |-> (res4.frame_bytes[1:0] == 2'b00))
    else $error("layer I length not whole slots");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted header lost at first stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy3 |=> v3 && $stable(q3))
    else $error("stalled stage changed");

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mpeg_audio_header_decode_core. Header words go in
// over the slave stream, and each decode that comes out of the master stream
// is compared field by field with a decode worked out in the bench. Stimulus
// starts with a short directed set: extreme bitrates and rates, every version
// and layer, and each way a header is rejected. Random headers follow, mostly
// well formed with some noise and some single-field corruptions. Both stream
// sides stall at random for part of the run.
// ----------------------------------------------------------------------------
module testbench;
  import mpahd_pkg::*;

  localparam int unsigned RANDOM_HEADERS = 750;
  localparam int unsigned DRAIN_CYCLES   = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  // Headers waiting to be sent, and decodes waiting to come back
  logic [31:0] header_q [$];
  res_t        decode_q [$];

  int unsigned sent_count   = 0;
  int unsigned error_count  = 0;
  int unsigned good_decodes = 0;
  int unsigned bad_decodes  = 0;

  // Bitrate rows: MPEG-1 layer I, II, III, then MPEG-2/2.5 layer I, II, III
  int unsigned rate_tab [0:5][0:15] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}};

  // MPEG-1 rates; MPEG-2 halves them and MPEG-2.5 quarters them
  int unsigned base_rate [0:2] = '{44100, 48000, 32000};

  mpeg_audio_header_decode_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected decode of one header word
  function automatic res_t decode_header(input logic [31:0] w);
    res_t        r;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [1:0]  sfi;
    logic [3:0]  bri;
    logic        pad;
    int unsigned row;
    int unsigned kbps;
    int unsigned fs;
    int unsigned spf;
    int unsigned nbytes;
    ver = w[20:19];
    lay = w[18:17];
    bri = w[15:12];
    sfi = w[11:10];
    pad = w[9];
    r = '0;
    r.version_code = ver;
    r.layer_code   = lay;
    r.protect_bit  = w[16];
    r.padding      = pad;
    if (w[31:21] == SYNC_WORD && ver != VER_RSVD && lay != LAYER_RSVD &&
        bri != BRI_FREE && bri != BRI_BAD && sfi != SFI_RSVD) begin
      // layer code 3 is layer I, so 3 - code gives the row within a group
      row  = ((ver == VER_MPEG1) ? 0 : 3) + (3 - lay);
      kbps = rate_tab[row][bri];
      fs   = base_rate[sfi] >> ((ver == VER_MPEG1) ? 0 : (ver == VER_MPEG2) ? 1 : 2);
      if (lay == LAYER_I) spf = 384;
      else if (lay == LAYER_II || ver == VER_MPEG1) spf = 1152;
      else spf = 576;
      if (lay == LAYER_I) nbytes = ((12 * kbps * 1000) / fs + pad) * 4;
      else nbytes = ((spf / 8) * kbps * 1000) / fs + pad;
      r.valid_res         = 1'b1;
      r.bitrate_kbps      = kbps[8:0];
      r.sample_rate_hz    = fs[15:0];
      r.samples_per_frame = spf[10:0];
      r.frame_bytes       = nbytes[11:0];
    end
    return r;
  endfunction

  // Header with sync set and the private bits clear
  function automatic logic [31:0] make_header(input logic [1:0] ver, input logic [1:0] lay,
                                              input logic [3:0] bri, input logic [1:0] sfi,
                                              input logic pad, input logic prot);
    return {SYNC_WORD, ver, lay, prot, bri, sfi, pad, 9'd0};
  endfunction

  // Random well-formed header, private bits random too
  function automatic logic [31:0] random_good_header();
    logic [1:0] ver;
    logic [1:0] lay;
    case ($urandom_range(0, 2))
      0:       ver = VER_MPEG25;
      1:       ver = VER_MPEG2;
      default: ver = VER_MPEG1;
    endcase
    case ($urandom_range(0, 2))
      0:       lay = LAYER_I;
      1:       lay = LAYER_II;
      default: lay = LAYER_III;
    endcase
    return make_header(ver, lay, 4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)),
                       1'($urandom), 1'($urandom)) | 32'($urandom_range(0, 511));
  endfunction

  // Stall percentages per phase: sender/receiver 38/54, then 54/38, then none
  function automatic int unsigned send_idle_pct(input int unsigned n);
    return (n < 275) ? 38 : (n < 525) ? 54 : 0;
  endfunction

  function automatic int unsigned recv_idle_pct(input int unsigned n);
    return (n < 275) ? 54 : (n < 525) ? 38 : 0;
  endfunction

  task automatic check_field(input string name, input int unsigned expected,
                             input int unsigned actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endtask

  // Driver: holds a header until it is taken, then maybe idles
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      sent_count <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_q.push_back(decode_header(s_tdata));
        sent_count <= sent_count + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (header_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(sent_count)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= header_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each decode transaction, then picks the next ready
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[54:0]);
        if (decode_q.size() == 0) begin
          $error("decode transaction with no header pending: m_tdata %h", m_tdata);
          error_count++;
        end else begin
          want = decode_q.pop_front();
          if (want.valid_res) good_decodes++;
          else bad_decodes++;
          check_field("valid_res", want.valid_res, got.valid_res);
          check_field("version_code", want.version_code, got.version_code);
          check_field("layer_code", want.layer_code, got.layer_code);
          check_field("protect_bit", want.protect_bit, got.protect_bit);
          check_field("padding", want.padding, got.padding);
          check_field("bitrate_kbps", want.bitrate_kbps, got.bitrate_kbps);
          check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
          check_field("samples_per_frame", want.samples_per_frame, got.samples_per_frame);
          check_field("frame_bytes", want.frame_bytes, got.frame_bytes);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct(sent_count));
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [31:0] w;
    int unsigned pick;

    // Directed: corner bitrates and rates for each version and layer
    header_q.push_back(make_header(VER_MPEG1, LAYER_I, 4'd14, 2'd2, 1'b1, 1'b1));
    header_q.push_back(make_header(VER_MPEG1, LAYER_I, 4'd1, 2'd1, 1'b0, 1'b0));
    header_q.push_back(make_header(VER_MPEG1, LAYER_II, 4'd1, 2'd0, 1'b0, 1'b0));
    header_q.push_back(make_header(VER_MPEG1, LAYER_II, 4'd14, 2'd2, 1'b1, 1'b1));
    header_q.push_back(make_header(VER_MPEG1, LAYER_III, 4'd9, 2'd0, 1'b1, 1'b1));
    // MPEG-2 layer I at index 1 must read 32 kbit/s
    header_q.push_back(make_header(VER_MPEG2, LAYER_I, 4'd1, 2'd1, 1'b0, 1'b1));
    header_q.push_back(make_header(VER_MPEG2, LAYER_II, 4'd14, 2'd2, 1'b0, 1'b1));
    header_q.push_back(make_header(VER_MPEG2, LAYER_III, 4'd8, 2'd1, 1'b1, 1'b0));
    header_q.push_back(make_header(VER_MPEG25, LAYER_I, 4'd14, 2'd2, 1'b1, 1'b0));
    // longest frame: low rate, top bitrate, padded
    header_q.push_back(make_header(VER_MPEG25, LAYER_II, 4'd14, 2'd2, 1'b1, 1'b1));
    header_q.push_back(make_header(VER_MPEG25, LAYER_III, 4'd1, 2'd0, 1'b0, 1'b1));
    header_q.push_back(make_header(VER_MPEG1, LAYER_III, 4'd5, 2'd1, 1'b1, 1'b0) | 32'h1FF);
    // Rejections: each check on its own, then all-zero, all-one and sync-only words
    w = make_header(VER_MPEG1, LAYER_III, 4'd9, 2'd0, 1'b0, 1'b1);
    header_q.push_back(w & ~32'h0020_0000);
    header_q.push_back(w & ~32'h8000_0000);
    header_q.push_back(make_header(VER_RSVD, LAYER_III, 4'd9, 2'd0, 1'b1, 1'b1));
    header_q.push_back(make_header(VER_MPEG1, LAYER_RSVD, 4'd9, 2'd0, 1'b1, 1'b1));
    header_q.push_back(make_header(VER_MPEG2, LAYER_II, BRI_FREE, 2'd1, 1'b1, 1'b0));
    header_q.push_back(make_header(VER_MPEG1, LAYER_I, BRI_BAD, 2'd0, 1'b0, 1'b1));
    header_q.push_back(make_header(VER_MPEG25, LAYER_III, 4'd3, SFI_RSVD, 1'b1, 1'b1));
    header_q.push_back(32'h0000_0000);
    header_q.push_back(32'hFFFF_FFFF);
    header_q.push_back(32'hFFE0_0000);

    // Random: mostly well formed, some noise, some with one field broken
    for (int unsigned i = 0; i < RANDOM_HEADERS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        w = random_good_header();
      end else if (pick < 85) begin
        w = $urandom;
      end else begin
        w = random_good_header();
        case ($urandom_range(0, 5))
          0:       w[21 + $urandom_range(0, 10)] = 1'b0;
          1:       w[20:19] = VER_RSVD;
          2:       w[18:17] = LAYER_RSVD;
          3:       w[15:12] = BRI_FREE;
          4:       w[15:12] = BRI_BAD;
          default: w[11:10] = SFI_RSVD;
        endcase
      end
      header_q.push_back(w);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for every header to go in and every decode to come out
    do @(negedge clk);
    while (header_q.size() != 0 || s_tvalid || decode_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d headers: %0d decoded as valid, %0d rejected",
             sent_count, good_decodes, bad_decodes);
    $display("all versions, layers, bitrate and sample-rate codes, under both-side stalls");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> mpeg_audio_header_decode_core.f
rtl/mpahd_pkg.sv
rtl/mpeg_audio_header_decode_core.sv
bench/testbench.sv
